// ===== rtl/nft_pkg.sv =====
// Shared types and constants for the noise floor tracker.
package nft_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int ADDR_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int LVL_W      = 12;
  localparam int EXT_W      = LVL_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_CLAMP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_GUARD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEECH_MARGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_QUIET_LEVEL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLED_LEVEL = 3'd6;

  typedef struct packed {
    logic signed [LVL_W-1:0] level_db;
  } level_beat_t;

  typedef struct packed {
    logic signed [LVL_W-1:0] noise_estimate;
    logic                    changed;
  } est_beat_t;

  // Controller to datapath commands
  typedef struct packed {
    logic eval;
    logic scan;
    logic finish;
    logic load_out;
  } nft_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic collect;
    logic close;
    logic scan_done;
  } nft_sts_t;

endpackage

// ===== rtl/nft_if.sv =====
// Valid/ready channel interfaces for level input and estimate output.
interface nft_level_if;
  import nft_pkg::*;
  logic        valid;
  logic        ready;
  level_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nft_est_if;
  import nft_pkg::*;
  logic      valid;
  logic      ready;
  est_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/nft_dp.sv =====
// Datapath: config registers, estimate, candidate window memory and min scan.
module nft_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_fire,
  input  logic signed [nft_pkg::LVL_W-1:0]      in_level,
  input  logic                                  cfg_wr_en,
  input  logic [nft_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [nft_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  nft_pkg::nft_cmd_t                     cmd,
  output nft_pkg::nft_sts_t                     sts,
  output nft_pkg::est_beat_t                    out_beat
);
  import nft_pkg::*;

  logic [6:0]              window_length;
  logic signed [11:0]      floor_clamp;
  logic [10:0]             rise_step;
  logic [10:0]             drop_guard;
  logic [10:0]             speech_margin;
  logic signed [11:0]      quiet_level;
  logic signed [11:0]      settled_level;

  logic signed [LVL_W-1:0] level_r;
  logic signed [LVL_W-1:0] estimate;
  logic [CNT_W-1:0]        fill_count;
  logic                    chg;

  logic signed [LVL_W-1:0] mem [MAX_WINDOW];
  logic signed [LVL_W-1:0] rd_data;
  logic                    rd_vld;
  logic [CNT_W-1:0]        idx;
  logic signed [LVL_W-1:0] win_min;

  logic [CNT_W-1:0]        eff_len;
  logic signed [EXT_W-1:0] lvl_x, est_x, min_x, diff_x;
  logic                    is_drop, is_cut, is_speech, collect;
  logic [ADDR_W-1:0]       wr_ptr;
  logic [CNT_W-1:0]        fill_inc;
  logic signed [LVL_W-1:0] drop_val;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= 7'd16;
      floor_clamp   <= -12'sd1280;
      rise_step     <= 11'd112;
      drop_guard    <= 11'd160;
      speech_margin <= 11'd336;
      quiet_level   <= -12'sd640;
      settled_level <= -12'sd896;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data[6:0];
        REG_FLOOR_CLAMP:   floor_clamp   <= cfg_data;
        REG_RISE_STEP:     rise_step     <= cfg_data[10:0];
        REG_DROP_GUARD:    drop_guard    <= cfg_data[10:0];
        REG_SPEECH_MARGIN: speech_margin <= cfg_data[10:0];
        REG_QUIET_LEVEL:   quiet_level   <= cfg_data;
        REG_SETTLED_LEVEL: settled_level <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp window length into 1..MAX_WINDOW
  always_comb begin
    if (window_length == '0) begin
      eff_len = CNT_W'(1);
    end else if (window_length > 7'(MAX_WINDOW)) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = window_length[CNT_W-1:0];
    end
  end

  // Classify the held level
  assign lvl_x     = EXT_W'(level_r);
  assign est_x     = EXT_W'(estimate);
  assign is_drop   = lvl_x < est_x;
  assign is_cut    = (est_x < EXT_W'(quiet_level)) &&
                     (lvl_x < est_x - $signed({3'b000, drop_guard}));
  assign is_speech = (lvl_x > est_x + $signed({3'b000, speech_margin})) &&
                     (level_r > quiet_level) && (estimate > settled_level);
  assign collect   = !is_drop && !is_speech;
  assign drop_val  = (level_r > floor_clamp) ? level_r : floor_clamp;

  assign wr_ptr   = (fill_count >= CNT_W'(MAX_WINDOW)) ? ADDR_W'(MAX_WINDOW - 1)
                                                       : fill_count[ADDR_W-1:0];
  assign fill_inc = {1'b0, wr_ptr} + CNT_W'(1);

  assign sts.collect   = collect;
  assign sts.close     = fill_inc >= eff_len;
  assign sts.scan_done = (idx == eff_len) && !rd_vld;

  // Window minimum against the estimate
  assign min_x  = EXT_W'(win_min);
  assign diff_x = min_x - est_x;

  // Window memory: write on collect, registered read during scan
  always_ff @(posedge clk) begin
    if (cmd.eval && collect) begin
      mem[wr_ptr] <= level_r;
    end
    rd_data <= mem[idx[ADDR_W-1:0]];
  end

  // Hold the accepted level
  always_ff @(posedge clk) begin
    if (in_fire) begin
      level_r <= in_level;
    end
  end

  // Estimate, fill count and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate   <= '0;
      fill_count <= '0;
      chg        <= 1'b0;
      rd_vld     <= 1'b0;
      idx        <= '0;
      win_min    <= '0;
    end else begin
      if (cmd.eval) begin
        idx     <= '0;
        win_min <= '0;
        rd_vld  <= 1'b0;
        if (is_drop && !is_cut) begin
          estimate   <= drop_val;
          fill_count <= '0;
          chg        <= 1'b1;
        end else if (collect) begin
          fill_count <= fill_inc;
          chg        <= 1'b0;
        end else begin
          chg <= 1'b0;
        end
      end
      if (cmd.scan) begin
        // advance the read pointer and fold returned entries into the minimum
        if (idx < eff_len) begin
          idx    <= idx + CNT_W'(1);
          rd_vld <= 1'b1;
        end else begin
          rd_vld <= 1'b0;
        end
        if (rd_vld && (rd_data < win_min)) begin
          win_min <= rd_data;
        end
      end
      if (cmd.finish) begin
        if (diff_x > $signed({3'b000, rise_step})) begin
          estimate <= LVL_W'(est_x + $signed({3'b000, rise_step}));
        end else begin
          estimate <= win_min;
        end
        fill_count <= '0;
        chg        <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_beat.noise_estimate <= estimate;
      out_beat.changed        <= chg;
    end
  end

endmodule

// ===== rtl/nft_ctrl.sv =====
// Controller: sequences accept, evaluation, window scan and result handoff.
module nft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  nft_pkg::nft_sts_t sts,
  output nft_pkg::nft_cmd_t cmd
);
  import nft_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = (sts.collect && sts.close) ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          cmd.finish = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/noise_floor_tracker_guarded_top.sv =====
// Noise floor tracker with cut guard and speech rejection: top level.
// One level beat in, one estimate beat out, one item at a time. An item that
// does not close the window is evaluated and then handed off; one that closes
// it adds a scan of the window memory, one entry a cycle, before the handoff.
// Output stalls delay the handoff.
// Synchronous reset: estimate 0 dB, window empty, registers to defaults.
module noise_floor_tracker_guarded_top (
  input  logic                                  clk,
  input  logic                                  rst,
  nft_level_if.sink                             in_ch,
  nft_est_if.source                             out_ch,
  input  logic                                  cfg_wr_en,
  input  logic [nft_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [nft_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import nft_pkg::*;

  nft_cmd_t  cmd;
  nft_sts_t  sts;
  est_beat_t out_beat;
  logic      in_ready;

  assign in_ch.ready = in_ready;
  assign out_ch.data = out_beat;

  nft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nft_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_ch.valid && in_ready),
    .in_level  (in_ch.data.level_db),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_beat  (out_beat)
  );

endmodule
